>>> rtl/mbr_partition_table_parser_core_macros.svh
// Assertion macros shared by the partition table parser RTL.
`ifndef MBR_PARTITION_TABLE_PARSER_CORE_MACROS_SVH
`define MBR_PARTITION_TABLE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MBRPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbrpt same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define MBRPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbrpt next-cycle check failed");

`endif

>>> rtl/mbrpt_pkg.sv
// Types, constants and helpers for the partition table parser.
`timescale 1ns / 1ps
package mbrpt_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int CNT_W     = 3;
    localparam int POS_W     = 9;

    localparam logic [POS_W-1:0] POS_FIRST = 9'd0;
    localparam logic [POS_W-1:0] POS_FAT1  = 9'd1;
    localparam logic [POS_W-1:0] POS_FAT2  = 9'd2;
    localparam logic [POS_W-1:0] TABLE_OFS = 9'd446;
    localparam logic [POS_W-1:0] SIG_OFS   = 9'd510;
    localparam logic [POS_W-1:0] POS_LAST  = 9'd511;

    localparam logic [3:0] OFF_TYPE   = 4'd4;
    localparam logic [3:0] OFF_START0 = 4'd8;
    localparam logic [3:0] OFF_START3 = 4'd11;
    localparam logic [3:0] OFF_SIZE0  = 4'd12;
    localparam logic [3:0] OFF_SIZE3  = 4'd15;

    localparam logic [7:0] SIG_LO    = 8'h55;
    localparam logic [7:0] SIG_HI    = 8'hAA;
    localparam logic [7:0] FAT_B0    = 8'hEB;
    localparam logic [7:0] FAT_B1    = 8'h58;
    localparam logic [7:0] FAT_B2    = 8'h90;
    localparam logic [7:0] FAT_TYPE  = 8'h01;
    localparam logic [7:0] TYPE_EXT  = 8'h05;
    localparam logic [7:0] TYPE_EXTL = 8'h0F;
    localparam logic [7:0] TYPE_EXTX = 8'h85;

    localparam logic [1:0] FAT_NONE = 2'd0;
    localparam logic [1:0] FAT_M1   = 2'd1;
    localparam logic [1:0] FAT_M2   = 2'd2;
    localparam logic [1:0] FAT_M3   = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIG = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;

    typedef struct packed {
        logic [7:0]  part_type;
        logic [7:0]  part_id;
        logic [31:0] start_sector;
        logic [31:0] size_sectors;
        logic [31:0] end_sector;
        logic        ext_flag;
    } entry_t;

    typedef struct packed {
        logic       entry_valid;
        logic [1:0] status;
        entry_t     ent;
    } res_t;

    function automatic logic ext_type(input logic [7:0] t);
        return (t == TYPE_EXT) || (t == TYPE_EXTL) || (t == TYPE_EXTX);
    endfunction

endpackage

>>> rtl/mbrpt_sort_cell.sv
// One cell of the insertion-sort row: holds one entry, keyed by start sector.
`timescale 1ns / 1ps
module mbrpt_sort_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             insert,
    input  mbrpt_pkg::entry_t new_entry,
    input  logic             left_stay,
    input  logic             left_valid,
    input  mbrpt_pkg::entry_t left_entry,
    output logic             stay,
    output logic             valid,
    output mbrpt_pkg::entry_t entry
);
    import mbrpt_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;

    // Keep our entry when it sorts at or before the new one (stable order).
    assign stay = valid_reg && (entry_reg.start_sector <= new_entry.start_sector);

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (insert && !stay)
        begin
            if (left_stay)
            begin
                valid_next = 1'b1;
                entry_next = new_entry;
            end
            else
            begin
                // shift right: take the neighbor's entry
                valid_next = left_valid;
                entry_next = left_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

>>> rtl/mbrpt_out_queue.sv
// Result queue: loaded at sector end, drained one result per transfer.
`timescale 1ns / 1ps
module mbrpt_out_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic [mbrpt_pkg::CNT_W-1:0] load_cnt,
    input  mbrpt_pkg::res_t             load_res [mbrpt_pkg::NUM_SLOTS],
    input  logic                        pop,
    output logic                        busy,
    output logic                        last,
    output mbrpt_pkg::res_t             head
);
    import mbrpt_pkg::*;

    res_t             q_reg [NUM_SLOTS];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = load_cnt;
        end
        else if (pop && (cnt_reg != '0))
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Advance the row toward the head on each transfer.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= load_res;
        end
        else if (pop)
        begin
            for (int i = 0; i < NUM_SLOTS - 1; i++)
            begin
                q_reg[i] <= q_reg[i+1];
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign last = (cnt_reg == CNT_W'(1));
    assign head = q_reg[0];

endmodule

>>> rtl/mbr_partition_table_parser_core.sv
// Top level: boot sector byte stream in, sorted partition entries out.
// Throughput: one sector byte per cycle while s_tready is high, sectors back to back.
// Latency: the first result is offered the cycle after byte 511 transfers,
// then up to three more results follow at one per cycle as the sink takes them.
// Byte 511 waits only while the previous sector's results are still queued.
// Reset (rst_n low, asynchronous) clears the byte position, the sort row and the queue.
`timescale 1ns / 1ps
`include "mbr_partition_table_parser_core_macros.svh"
module mbr_partition_table_parser_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // sector_byte[7:0], sector_base[39:8], first_id[47:40]
    input  logic         s_tuser,   // is_logical[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // part_type[7:0], part_id[15:8], start_sector[47:16],
                                    // size_sectors[79:48], end_sector[111:80],
                                    // ext_flag[112], zero[119:113]
    output logic [2:0]   m_tuser,   // entry_valid[0], status[2:1]
    output logic         m_tlast
);
    import mbrpt_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic             mode_reg;
    logic [31:0]      base_reg;
    logic [7:0]       lognum_reg;
    logic [1:0]       fat_reg;
    logic [7:0]       sig_reg;
    logic [7:0]       type_reg;
    logic [31:0]      start_reg;
    logic [23:0]      size_reg;
    logic [31:0]      ps_reg;

    logic             s_fire;
    logic [7:0]       b;
    logic             in_table;
    logic [POS_W-1:0] rel;
    logic [3:0]       off;
    logic [1:0]       slot;
    logic [31:0]      size_full;
    logic             entry_empty;
    logic             insert;
    logic             finish;
    logic             type_ext;
    entry_t           new_entry;

    logic             cell_stay  [NUM_SLOTS];
    logic             cell_valid [NUM_SLOTS];
    entry_t           cell_entry [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_vec;

    res_t             load_res [NUM_SLOTS];
    logic [CNT_W-1:0] load_cnt;
    logic             q_busy;
    logic             q_last;
    res_t             q_head;

    assign b        = s_tdata[7:0];
    assign s_tready = !((pos_reg == POS_LAST) && q_busy);
    assign s_fire   = s_tvalid && s_tready;
    assign finish   = s_fire && (pos_reg == POS_LAST);

    assign in_table = (pos_reg >= TABLE_OFS) && (pos_reg < SIG_OFS);
    assign rel      = pos_reg - TABLE_OFS;
    assign off      = rel[3:0];
    assign slot     = rel[5:4];
    assign type_ext = ext_type(type_reg);

    assign size_full   = {b, size_reg};
    assign entry_empty = (type_reg == '0) && (start_reg == '0) && (size_full == '0);
    assign insert      = s_fire && in_table && (off == OFF_SIZE3) && !entry_empty;

    always_comb
    begin
        new_entry.part_type    = type_reg;
        new_entry.start_sector = ps_reg;
        new_entry.size_sectors = size_full;
        new_entry.end_sector   = ps_reg + size_full;
        new_entry.ext_flag     = type_ext;
        if (!mode_reg)
        begin
            new_entry.part_id = 8'(slot) + 8'd1;
        end
        else if (type_ext)
        begin
            new_entry.part_id = 8'd0;
        end
        else
        begin
            new_entry.part_id = lognum_reg;
        end
    end

    // Byte position and per-sector header state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            mode_reg   <= 1'b0;
            base_reg   <= '0;
            lognum_reg <= '0;
            fat_reg    <= FAT_NONE;
            sig_reg    <= '0;
        end
        else if (s_fire)
        begin
            pos_reg <= pos_reg + POS_W'(1);
            if (pos_reg == POS_FIRST)
            begin
                mode_reg   <= s_tuser;
                base_reg   <= s_tdata[39:8];
                lognum_reg <= s_tdata[47:40];
                fat_reg    <= (b == FAT_B0) ? FAT_M1 : FAT_NONE;
            end
            else if (pos_reg == POS_FAT1)
            begin
                fat_reg <= ((fat_reg == FAT_M1) && (b == FAT_B1)) ? FAT_M2 : FAT_NONE;
            end
            else if (pos_reg == POS_FAT2)
            begin
                fat_reg <= ((fat_reg == FAT_M2) && (b == FAT_B2)) ? FAT_M3 : FAT_NONE;
            end
            if (pos_reg == SIG_OFS)
            begin
                sig_reg <= b;
            end
        end
    end

    // Assemble the current table entry; the sort key is formed once start is complete.
    always_ff @(posedge clk)
    begin
        if (s_fire && in_table)
        begin
            if (off == OFF_TYPE)
            begin
                type_reg <= b;
            end
            if ((off >= OFF_START0) && (off <= OFF_START3))
            begin
                start_reg <= {b, start_reg[31:8]};
            end
            if (off == OFF_SIZE0)
            begin
                ps_reg <= (mode_reg && !type_ext) ? (start_reg + base_reg) : start_reg;
            end
            if ((off >= OFF_SIZE0) && (off < OFF_SIZE3))
            begin
                size_reg <= {b, size_reg[23:8]};
            end
        end
    end

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            mbrpt_sort_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (finish),
                .insert     (insert),
                .new_entry  (new_entry),
                .left_stay  (1'b1),
                .left_valid (1'b0),
                .left_entry (new_entry),
                .stay       (cell_stay[i]),
                .valid      (cell_valid[i]),
                .entry      (cell_entry[i])
            );
        end
        else
        begin : g_body
            mbrpt_sort_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear      (finish),
                .insert     (insert),
                .new_entry  (new_entry),
                .left_stay  (cell_stay[i-1]),
                .left_valid (cell_valid[i-1]),
                .left_entry (cell_entry[i-1]),
                .stay       (cell_stay[i]),
                .valid      (cell_valid[i]),
                .entry      (cell_entry[i])
            );
        end
        assign valid_vec[i] = cell_valid[i];
    end

    // Results for the sector end: special cases collapse to a single result.
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            load_res[i].entry_valid = 1'b1;
            load_res[i].status      = STATUS_OK;
            load_res[i].ent         = cell_entry[i];
        end
        load_cnt = CNT_W'($countones(valid_vec));
        priority if (!mode_reg && ((sig_reg != SIG_LO) || (b != SIG_HI)))
        begin
            load_res[0]        = '0;
            load_res[0].status = STATUS_BAD_SIG;
            load_cnt           = CNT_W'(1);
        end
        else if (!mode_reg && (fat_reg == FAT_M3))
        begin
            load_res[0]               = '0;
            load_res[0].entry_valid   = 1'b1;
            load_res[0].status        = STATUS_OK;
            load_res[0].ent.part_type = FAT_TYPE;
            load_res[0].ent.part_id   = 8'd1;
            load_cnt                  = CNT_W'(1);
        end
        else if (valid_vec == '0)
        begin
            load_res[0]        = '0;
            load_res[0].status = STATUS_EMPTY;
            load_cnt           = CNT_W'(1);
        end
        else
        begin
            load_cnt = CNT_W'($countones(valid_vec));
        end
    end

    mbrpt_out_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (finish),
        .load_cnt (load_cnt),
        .load_res (load_res),
        .pop      (m_tready),
        .busy     (q_busy),
        .last     (q_last),
        .head     (q_head)
    );

    assign m_tvalid = q_busy;
    assign m_tlast  = q_last;
    assign m_tuser  = {q_head.status, q_head.entry_valid};
    assign m_tdata  = {7'b0, q_head.ent.ext_flag, q_head.ent.end_sector,
                       q_head.ent.size_sectors, q_head.ent.start_sector,
                       q_head.ent.part_id, q_head.ent.part_type};

    `MBRPT_ASSERT_IMP(a_load_empty, clk, rst_n, finish, !q_busy)
    `MBRPT_ASSERT_NXT(a_result_follows, clk, rst_n, finish, m_tvalid)
    `MBRPT_ASSERT_IMP(a_row_prefix, clk, rst_n, cell_valid[1], cell_valid[0])
    `MBRPT_ASSERT_IMP(a_row_sorted, clk, rst_n, cell_valid[1] && cell_valid[0], cell_entry[0].start_sector <= cell_entry[1].start_sector)

endmodule

>>> tb/mbr_partition_table_parser_core_tb.sv
// Self-checking testbench for the MBR/EBR partition table parser core.
`timescale 1ns / 1ps
module mbr_partition_table_parser_core_tb;
    import mbrpt_pkg::*;

    typedef struct {
        logic        valid;
        logic [1:0]  status;
        logic [7:0]  ptype;
        logic [7:0]  pid;
        logic [31:0] start;
        logic [31:0] size;
        logic [31:0] stop;
        logic        ext;
        logic        last_flag;
    } part_result_t;

    // Tracks the sector byte stream, predicts the partition list and checks it.
    class partition_scoreboard;
        part_result_t due_q[$];
        int          failures;
        int          results_due;
        bit [8:0]    pos;
        bit          mode;
        bit [31:0]   base;
        bit [7:0]    lid;
        bit [1:0]    fat;
        bit [7:0]    sig_lo;
        bit [7:0]    slot_type[4];
        bit [31:0]   slot_start[4];
        bit [31:0]   slot_size[4];

        function bit extended_code(bit [7:0] t);
            return t == TYPE_EXT || t == TYPE_EXTL || t == TYPE_EXTX;
        endfunction

        function part_result_t make_result(bit v, bit [1:0] st, bit [7:0] t, bit [7:0] id,
                                           bit [31:0] s, bit [31:0] z, bit x, bit l);
            part_result_t r;
            r.valid     = v;
            r.status    = st;
            r.ptype     = t;
            r.pid       = id;
            r.start     = s;
            r.size      = z;
            r.stop      = s + z;
            r.ext       = x;
            r.last_flag = l;
            return r;
        endfunction

        function void post_status(bit [1:0] st);
            due_q.push_back(make_result(1'b0, st, 8'h00, 8'h00, 32'd0, 32'd0, 1'b0, 1'b1));
            results_due++;
        endfunction

        function void close_sector(bit [7:0] b);
            part_result_t row[4];
            part_result_t cur;
            bit [31:0]    ps;
            bit [7:0]     id;
            int           n;
            int           j;
            n = 0;
            if (mode == 1'b0)
            begin
                if (sig_lo != SIG_LO || b != SIG_HI)
                begin
                    post_status(STATUS_BAD_SIG);
                    return;
                end
                if (fat == FAT_M3)
                begin
                    due_q.push_back(make_result(1'b1, STATUS_OK, FAT_TYPE, 8'd1,
                                                32'd0, 32'd0, 1'b0, 1'b1));
                    results_due++;
                    return;
                end
            end
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_type[i] == 8'h00 && slot_start[i] == 32'd0 && slot_size[i] == 32'd0)
                    continue;
                if (mode == 1'b0)
                begin
                    id = 8'(i + 1);
                    ps = slot_start[i];
                end
                else if (extended_code(slot_type[i]))
                begin
                    id = 8'd0;
                    ps = slot_start[i];
                end
                else
                begin
                    id = lid;
                    ps = slot_start[i] + base;
                end
                cur = make_result(1'b1, STATUS_OK, slot_type[i], id, ps, slot_size[i],
                                  extended_code(slot_type[i]), 1'b0);
                // insert after every entry whose start is not greater: keeps slot order on ties
                j = n;
                while (j > 0 && row[j-1].start > ps)
                begin
                    row[j] = row[j-1];
                    j--;
                end
                row[j] = cur;
                n++;
            end
            if (n == 0)
            begin
                post_status(STATUS_EMPTY);
                return;
            end
            row[n-1].last_flag = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                due_q.push_back(row[i]);
                results_due++;
            end
        endfunction

        function void note_byte(bit [7:0] b, bit lg, bit [31:0] bs, bit [7:0] id);
            bit [8:0] rel;
            int       sh;
            if (pos == POS_FIRST)
            begin
                mode = lg;
                base = bs;
                lid  = id;
                fat  = (b == FAT_B0) ? FAT_M1 : FAT_NONE;
            end
            else if (pos == POS_FAT1)
                fat = (fat == FAT_M1 && b == FAT_B1) ? FAT_M2 : FAT_NONE;
            else if (pos == POS_FAT2)
                fat = (fat == FAT_M2 && b == FAT_B2) ? FAT_M3 : FAT_NONE;

            if (pos >= TABLE_OFS && pos < SIG_OFS)
            begin
                rel = pos - TABLE_OFS;
                if (rel[3:0] == OFF_TYPE)
                    slot_type[rel[5:4]] = b;
                else if (rel[3:0] >= OFF_START0 && rel[3:0] <= OFF_START3)
                begin
                    sh = 8 * (rel[3:0] - OFF_START0);
                    slot_start[rel[5:4]][sh +: 8] = b;
                end
                else if (rel[3:0] >= OFF_SIZE0)
                begin
                    sh = 8 * (rel[3:0] - OFF_SIZE0);
                    slot_size[rel[5:4]][sh +: 8] = b;
                end
            end
            else if (pos == SIG_OFS)
                sig_lo = b;
            else if (pos == POS_LAST)
                close_sector(b);
            pos = pos + 9'd1;
        endfunction

        function string show(part_result_t r);
            return $sformatf("valid=%0b status=%0d type=%02h id=%02h start=%08h size=%08h end=%08h ext=%0b last=%0b",
                             r.valid, r.status, r.ptype, r.pid, r.start, r.size, r.stop,
                             r.ext, r.last_flag);
        endfunction

        function void check_entry(logic [119:0] d, logic [2:0] u, logic l);
            part_result_t got;
            part_result_t want;
            got.valid     = u[0];
            got.status    = u[2:1];
            got.ptype     = d[7:0];
            got.pid       = d[15:8];
            got.start     = d[47:16];
            got.size      = d[79:48];
            got.stop      = d[111:80];
            got.ext       = d[112];
            got.last_flag = l;
            if (due_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: %s", show(got));
                return;
            end
            want = due_q.pop_front();
            if (got.valid !== want.valid || got.status !== want.status ||
                got.ptype !== want.ptype || got.pid !== want.pid ||
                got.start !== want.start || got.size !== want.size ||
                got.stop !== want.stop || got.ext !== want.ext ||
                got.last_flag !== want.last_flag)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    partition_scoreboard sb = new();

    bit [7:0]  sec[512];
    bit [31:0] last_start;
    bit        steady;

    mbr_partition_table_parser_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Check each result transfer, then pick the sink's next ready state.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_entry(m_tdata, m_tuser, m_tlast);
        m_tready <= steady || ($urandom_range(0, 99) >= 16);
    end

    task automatic send_byte(input bit [7:0] b, input bit lg, input bit [31:0] bs,
                             input bit [7:0] id);
        while (!steady && $urandom_range(0, 99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {id, bs, b};
        s_tuser  <= lg;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b, lg, bs, id);
    endtask

    // Mode, base and id count only at byte 0; scramble them everywhere else.
    task automatic send_sector(input bit lg, input bit [31:0] bs, input bit [7:0] id);
        send_byte(sec[0], lg, bs, id);
        for (int i = 1; i < 512; i++)
            send_byte(sec[i], 1'($urandom_range(0, 1)), $urandom, 8'($urandom_range(0, 255)));
    endtask

    task automatic fill_sector();
        for (int i = 0; i < 512; i++)
            sec[i] = 8'($urandom_range(0, 255));
    endtask

    task automatic put_entry(input int slot, input bit [7:0] t, input bit [31:0] st,
                             input bit [31:0] sz);
        int ofs;
        ofs = int'(TABLE_OFS) + 16 * slot;
        sec[ofs + int'(OFF_TYPE)] = t;
        for (int k = 0; k < 4; k++)
        begin
            sec[ofs + int'(OFF_START0) + k] = st[8*k +: 8];
            sec[ofs + int'(OFF_SIZE0) + k]  = sz[8*k +: 8];
        end
    endtask

    task automatic set_header(input bit [7:0] b0, input bit [7:0] b1, input bit [7:0] b2);
        sec[0] = b0;
        sec[1] = b1;
        sec[2] = b2;
    endtask

    task automatic set_sig(input bit [7:0] lo, input bit [7:0] hi);
        sec[int'(SIG_OFS)]  = lo;
        sec[int'(POS_LAST)] = hi;
    endtask

    task automatic typical_table();
        put_entry(0, 8'h83, 32'h0000_0800, 32'h0010_0000);
        put_entry(1, TYPE_EXTL, 32'h0000_0010, 32'h0000_0400);
        put_entry(2, 8'h07, 32'h0000_0800, 32'h0000_0001);
        put_entry(3, 8'h00, 32'h0000_0000, 32'h0000_0000);
    endtask

    function automatic bit [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return 32'($urandom_range(0, 15));
            1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            2: return last_start;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [7:0] pick_type();
        case ($urandom_range(0, 5))
            0: return TYPE_EXT;
            1: return TYPE_EXTL;
            2: return TYPE_EXTX;
            3: return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_sector();
        bit        lg;
        bit [31:0] bs;
        bit [31:0] st;
        int        pick;
        fill_sector();
        lg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: bs = 32'd0;
            1: bs = 32'hFFFF_FFFF;
            default: bs = $urandom;
        endcase
        // keep a few sectors as pure noise
        if ($urandom_range(0, 99) >= 8)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                if ($urandom_range(0, 3) == 0)
                    put_entry(s, 8'h00, 32'd0, 32'd0);
                else
                begin
                    st = pick_value();
                    put_entry(s, pick_type(), st, pick_value());
                    last_start = st;
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 12)
                set_header(FAT_B0, FAT_B1, FAT_B2);
            else if (pick < 18)
                set_header(FAT_B0, FAT_B1, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 85)
                set_sig(SIG_LO, SIG_HI);
        end
        send_sector(lg, bs, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int n_rand;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        steady     = 1'b0;
        last_start = 32'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // unsorted starts, a tie on start, wrapping end, extended codes
        fill_sector();
        set_header(8'h00, 8'h00, 8'h00);
        put_entry(0, 8'h83, 32'd100, 32'd50);
        put_entry(1, TYPE_EXT, 32'd20, 32'hFFFF_FFFF);
        put_entry(2, 8'hFF, 32'd100, 32'd7);
        put_entry(3, TYPE_EXTX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_sig(SIG_LO, SIG_HI);
        send_sector(1'b0, 32'hFFFF_FFFF, 8'hFF);

        // entries that are non-empty through a single nonzero field
        fill_sector();
        set_header(8'h00, 8'h00, 8'h00);
        put_entry(0, 8'h00, 32'd0, 32'd9);
        put_entry(1, 8'h00, 32'd5, 32'd0);
        put_entry(2, 8'h00, 32'd0, 32'd0);
        put_entry(3, TYPE_EXTL, 32'd0, 32'd0);
        set_sig(SIG_LO, SIG_HI);
        send_sector(1'b0, 32'd0, 8'h00);

        // empty table
        fill_sector();
        set_header(8'h00, 8'h00, 8'h00);
        for (int s = 0; s < NUM_SLOTS; s++)
            put_entry(s, 8'h00, 32'd0, 32'd0);
        set_sig(SIG_LO, SIG_HI);
        send_sector(1'b0, 32'd0, 8'h00);

        // bad signatures
        fill_sector();
        set_header(8'h00, 8'h00, 8'h00);
        typical_table();
        set_sig(SIG_LO, 8'hAB);
        send_sector(1'b0, 32'd0, 8'h00);
        fill_sector();
        set_header(8'h00, 8'h00, 8'h00);
        typical_table();
        set_sig(SIG_HI, SIG_LO);
        send_sector(1'b0, 32'd0, 8'h00);

        // FAT boot sector with and without signature, then a near miss
        fill_sector();
        set_header(FAT_B0, FAT_B1, FAT_B2);
        typical_table();
        set_sig(SIG_LO, SIG_HI);
        send_sector(1'b0, 32'd0, 8'h00);
        fill_sector();
        set_header(FAT_B0, FAT_B1, FAT_B2);
        typical_table();
        set_sig(8'h00, 8'h00);
        send_sector(1'b0, 32'd0, 8'h00);
        fill_sector();
        set_header(FAT_B0, FAT_B1, 8'h91);
        typical_table();
        set_sig(SIG_LO, SIG_HI);
        send_sector(1'b0, 32'd0, 8'h00);

        // logical: signature and FAT header ignored, base wraps starts
        fill_sector();
        set_header(FAT_B0, FAT_B1, FAT_B2);
        put_entry(0, TYPE_EXT, 32'd3, 32'd100);
        put_entry(1, 8'h07, 32'h20, 32'd16);
        put_entry(2, TYPE_EXTL, 32'd1, 32'd1);
        put_entry(3, 8'h83, 32'd0, 32'hFFFF_FFFF);
        set_sig(8'h00, 8'h00);
        send_sector(1'b1, 32'hFFFF_FFF0, 8'hFF);

        fill_sector();
        for (int s = 0; s < NUM_SLOTS; s++)
            put_entry(s, 8'h00, 32'd0, 32'd0);
        set_sig(8'h12, 8'h34);
        send_sector(1'b1, 32'd0, 8'h00);

        fill_sector();
        put_entry(0, TYPE_EXTX, 32'd7, 32'd5);
        put_entry(1, 8'h0C, 32'd2, 32'hFFFF_FFFF);
        put_entry(2, TYPE_EXTL, 32'd7, 32'd0);
        put_entry(3, 8'h07, 32'd7, 32'd3);
        set_sig(SIG_LO, SIG_HI);
        send_sector(1'b1, 32'h8000_0000, 8'h5A);

        // random sectors until enough results have been produced
        n_rand = 0;
        while (sb.results_due < 100)
        begin
            steady = (n_rand >= 5 && n_rand < 9);
            random_sector();
            n_rand++;
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.due_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.due_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
